/* rtl/gam_pkg.sv */
// Shared constants and codes of the gamepad action mapper.
`timescale 1ns / 1ps
package gam_pkg;

  localparam int PLAYERS          = 4;
  localparam int ACTIONS          = 32;
  localparam int BUTTONS_PER_PORT = 18;
  localparam int PORTS            = 4;
  localparam int PAD_BITS         = PORTS * BUTTONS_PER_PORT;
  localparam int SLOTS            = 32;
  localparam int MAP_DEPTH        = PLAYERS * SLOTS;
  localparam int KEY_W            = 7;
  localparam int SLOT_W           = $clog2(SLOTS);
  localparam int PLAYER_W         = 2;
  localparam int MAP_AW           = PLAYER_W + SLOT_W;
  localparam int PAD_IDX_W        = $clog2(PAD_BITS);

  typedef enum logic [1:0] {
    OP_SET_MAP = 2'd0,
    OP_UPDATE  = 2'd1,
    OP_SCAN    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CFG_NUM_PLAYERS = 2'd0,
    CFG_STICK_LOW   = 2'd1,
    CFG_STICK_HIGH  = 2'd2
  } cfg_idx_t;

  localparam logic [2:0] NUM_PLAYERS_RST = 3'd1;
  localparam logic [7:0] STICK_LOW_RST   = 8'h40;
  localparam logic [7:0] STICK_HIGH_RST  = 8'hC0;

endpackage

/* rtl/gam_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module gam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/gam_pad_decode.sv */
// Decode of one pad port into its 18 button bits.
`timescale 1ns / 1ps
module gam_pad_decode
  import gam_pkg::*;
(
  input  logic [31:0]                 buttons,
  input  logic [15:0]                 stick,
  input  logic [7:0]                  stick_low_threshold,
  input  logic [7:0]                  stick_high_threshold,
  output logic [BUTTONS_PER_PORT-1:0] pad
);

  logic [7:0] vert;
  logic [7:0] horiz;

  assign vert  = stick[15:8];
  assign horiz = stick[7:0];

  always_comb begin
    // The low 16 buttons are active low.
    pad[15:0] = ~buttons[15:0];
    pad[4]    = pad[4] | (vert  <= stick_low_threshold);
    pad[5]    = pad[5] | (vert  >= stick_high_threshold);
    pad[6]    = pad[6] | (horiz <= stick_low_threshold);
    pad[7]    = pad[7] | (horiz >= stick_high_threshold);
    pad[16]   = buttons[31];
    pad[17]   = buttons[23];
  end

endmodule

/* rtl/gamepad_action_mapper.sv */
// Top level of the gamepad action mapper: request sequencer and shared pad bit selector.
//
//   channel | signals                               | role
//   --------+---------------------------------------+-------------------------------
//   in      | in_valid/in_ready, opcode..stick_port3 | one request per handshake
//   out     | out_valid/out_ready, result fields     | zero to four results a request
//   cfg     | cfg_valid/cfg_ready, cfg_index/data    | register write, always ready
//
// After reset the mapping store is cleared one entry a cycle, all 128 entries, before
// the first request is taken. A set-mapping request searches the flag bits from bit 0
// and writes the key into the slot of the first set bit (or the last slot); an update
// does 32 store reads for each player in turn, waits out the store read latency and
// then emits that player's result; a scan tests one pad bit per cycle until a set bit
// or the last pad bit, then emits the result.
// A result waits in the output register; the sequencer stalls only when it has
// a further result and that register is still full.
`timescale 1ns / 1ps
module gamepad_action_mapper
  import gam_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          opcode,
  input  logic [1:0]          player,
  input  logic [31:0]         action_flag,
  input  logic [6:0]          key_code,
  input  logic [31:0]         buttons_port0,
  input  logic [31:0]         buttons_port1,
  input  logic [31:0]         buttons_port2,
  input  logic [31:0]         buttons_port3,
  input  logic [15:0]         stick_port0,
  input  logic [15:0]         stick_port1,
  input  logic [15:0]         stick_port2,
  input  logic [15:0]         stick_port3,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          result_player,
  output logic [31:0]         held_actions,
  output logic [31:0]         new_actions,
  output logic [6:0]          scanned_key,
  output logic                last,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_SLOT  = 8'b0000_0100,
    S_UPD   = 8'b0000_1000,
    S_DRAIN = 8'b0001_0000,
    S_UEMIT = 8'b0010_0000,
    S_SCAN  = 8'b0100_0000,
    S_SEMIT = 8'b1000_0000
  } state_t;

  state_t state;

  logic [2:0]             num_players;
  logic [7:0]             stick_low_threshold;
  logic [7:0]             stick_high_threshold;

  logic [PAD_BITS-1:0]    pads_in;
  logic [PAD_BITS-1:0]    pads;
  logic [31:0]            flag_sh;
  logic [PLAYER_W-1:0]    req_player;
  logic [KEY_W-1:0]       req_key;
  logic [2:0]             n_play;
  logic [PLAYER_W-1:0]    plr;
  logic [SLOT_W-1:0]      slot_cnt;
  logic [6:0]             cnt;
  logic                   rd_vld;
  logic [SLOT_W-1:0]      rd_slot;
  logic [31:0]            mask;
  logic [KEY_W-1:0]       scan_key;
  logic                   armed;
  logic [31:0]            held [PLAYERS];

  logic                   wr_en;
  logic [MAP_AW-1:0]      wr_addr;
  logic [KEY_W-1:0]       wr_data;
  logic [MAP_AW-1:0]      rd_addr;
  logic [KEY_W-1:0]       rd_data;

  logic [PAD_IDX_W-1:0]   sel_idx;
  logic                   sel_bit;
  logic                   slot_found;
  logic                   out_free;
  logic                   out_load;
  logic                   hit;
  logic [2:0]             n_req;
  logic                   is_last;

  gam_pad_decode u_pad0 (
    .buttons(buttons_port0), .stick(stick_port0),
    .stick_low_threshold(stick_low_threshold), .stick_high_threshold(stick_high_threshold),
    .pad(pads_in[0*BUTTONS_PER_PORT +: BUTTONS_PER_PORT])
  );
  gam_pad_decode u_pad1 (
    .buttons(buttons_port1), .stick(stick_port1),
    .stick_low_threshold(stick_low_threshold), .stick_high_threshold(stick_high_threshold),
    .pad(pads_in[1*BUTTONS_PER_PORT +: BUTTONS_PER_PORT])
  );
  gam_pad_decode u_pad2 (
    .buttons(buttons_port2), .stick(stick_port2),
    .stick_low_threshold(stick_low_threshold), .stick_high_threshold(stick_high_threshold),
    .pad(pads_in[2*BUTTONS_PER_PORT +: BUTTONS_PER_PORT])
  );
  gam_pad_decode u_pad3 (
    .buttons(buttons_port3), .stick(stick_port3),
    .stick_low_threshold(stick_low_threshold), .stick_high_threshold(stick_high_threshold),
    .pad(pads_in[3*BUTTONS_PER_PORT +: BUTTONS_PER_PORT])
  );

  gam_ram #(
    .WIDTH(KEY_W),
    .DEPTH(MAP_DEPTH)
  ) u_key_map (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign out_load  = out_free && ((state == S_UEMIT) || (state == S_SEMIT));

  assign slot_found = flag_sh[0] || (slot_cnt == SLOT_W'(SLOTS - 1));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {req_player, slot_cnt};
    wr_data = req_key;
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = MAP_AW'(cnt);
      wr_data = '0;
    end else if (state == S_SLOT && slot_found) begin
      wr_en = 1'b1;
    end
  end

  assign rd_addr = {plr, slot_cnt};

  // A key code of zero wraps to an index past the pad bits, so the range check
  // also rejects unmapped entries.
  assign sel_idx = (state == S_SCAN) ? PAD_IDX_W'(cnt) : PAD_IDX_W'(rd_data - KEY_W'(1));
  assign sel_bit = (sel_idx < PAD_IDX_W'(PAD_BITS)) && pads[sel_idx];
  assign hit     = sel_bit && ({1'b0, rd_slot} < (SLOT_W + 1)'(ACTIONS));

  assign n_req   = (num_players > 3'(PLAYERS)) ? 3'(PLAYERS) : num_players;
  assign is_last = (({1'b0, plr} + 3'd1) == n_play);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_players          <= NUM_PLAYERS_RST;
      stick_low_threshold  <= STICK_LOW_RST;
      stick_high_threshold <= STICK_HIGH_RST;
    end else if (cfg_valid && cfg_ready) begin
      priority case (cfg_index)
        CFG_NUM_PLAYERS: num_players          <= cfg_data[2:0];
        CFG_STICK_LOW:   stick_low_threshold  <= cfg_data;
        CFG_STICK_HIGH:  stick_high_threshold <= cfg_data;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      rd_vld    <= 1'b0;
      armed     <= 1'b0;
      out_valid <= 1'b0;
      for (int p = 0; p < PLAYERS; p++) begin
        held[p] <= '0;
      end
    end else begin
      rd_vld  <= (state == S_UPD);
      rd_slot <= slot_cnt;
      if (rd_vld) begin
        // Slot results shift in from the top, so slot i lands at bit i.
        mask <= {hit, mask[31:1]};
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + 7'd1;
          if (cnt == 7'(MAP_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_valid) begin
            pads       <= pads_in;
            flag_sh    <= action_flag;
            req_player <= player;
            req_key    <= key_code;
            n_play     <= n_req;
            plr        <= '0;
            slot_cnt   <= '0;
            cnt        <= '0;
            unique case (opcode)
              OP_SET_MAP: state <= ({1'b0, player} < 3'(PLAYERS)) ? S_SLOT : S_IDLE;
              OP_UPDATE:  state <= (n_req == 3'd0) ? S_IDLE : S_UPD;
              OP_SCAN:    state <= S_SCAN;
              default:    state <= S_IDLE;
            endcase
          end
        end

        S_SLOT: begin
          if (slot_found) begin
            held[req_player] <= '0;
            state            <= S_IDLE;
          end else begin
            flag_sh  <= flag_sh >> 1;
            slot_cnt <= slot_cnt + SLOT_W'(1);
          end
        end

        S_UPD: begin
          slot_cnt <= slot_cnt + SLOT_W'(1);
          if (slot_cnt == SLOT_W'(SLOTS - 1)) begin
            state <= S_DRAIN;
          end
        end

        S_DRAIN: begin
          state <= S_UEMIT;
        end

        S_UEMIT: begin
          if (out_free) begin
            result_player <= plr;
            held_actions  <= mask;
            new_actions   <= mask & ~held[plr];
            scanned_key   <= '0;
            last          <= is_last;
            held[plr]     <= mask;
            if (is_last) begin
              state <= S_IDLE;
            end else begin
              plr   <= plr + PLAYER_W'(1);
              state <= S_UPD;
            end
          end
        end

        S_SCAN: begin
          if (sel_bit) begin
            scan_key <= cnt + 7'd1;
            state    <= S_SEMIT;
          end else if (cnt == 7'(PAD_BITS - 1)) begin
            scan_key <= '0;
            state    <= S_SEMIT;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end

        S_SEMIT: begin
          if (out_free) begin
            result_player <= '0;
            held_actions  <= '0;
            new_actions   <= '0;
            last          <= 1'b1;
            if (armed && scan_key != '0) begin
              scanned_key <= scan_key;
              armed       <= 1'b0;
            end else begin
              scanned_key <= '0;
              armed       <= (scan_key == '0);
            end
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
